/* rtl/walus_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walus_pkg
// Shared types and constants of the weekday alarm unit with snooze.
// ----------------------------------------------------------------------------
package walus_pkg;

  localparam int SLOT_REGS       = 4;
  localparam int SLOT_W          = 19;
  localparam int SNOOZE_W        = 11;
  localparam int ACC_W           = 12;
  localparam int CFG_IDX_W       = 3;
  localparam int MINUTES_PER_DAY = 24 * 60;
  localparam int DAYS_PER_WEEK   = 7;

  // alarm slot packing
  localparam int SLOT_EN_BIT   = 18;
  localparam int SLOT_MASK_LSB = 11;
  localparam int SLOT_HOUR_LSB = 6;

  // register index of the snooze length; slots sit below it
  localparam logic [CFG_IDX_W-1:0] REG_SNOOZE = 3'd4;

  typedef logic [1:0] slot_idx_t;

  typedef enum logic [1:0] {
    KIND_TIME    = 2'd0,
    KIND_SNOOZE  = 2'd1,
    KIND_DISMISS = 2'd2,
    KIND_RSVD    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CUR_HI,
    ST_CUR_LO,
    ST_DATE,
    ST_SNZ_CMP,
    ST_SCAN,
    ST_SNZ_ADD,
    ST_SNZ_MOD,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             ge;   // a >= b on a subtract
  } alu_rsp_t;

endpackage

`default_nettype wire

/* rtl/walus_alu.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walus_alu
// Shared 12-bit add / subtract-compare unit used by the sequencer.
// ----------------------------------------------------------------------------
module walus_alu (
  input  walus_pkg::alu_req_t req,
  output walus_pkg::alu_rsp_t rsp
);
  import walus_pkg::*;

  logic [ACC_W:0] diff;

  assign diff = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      ALU_ADD: begin
        rsp.res = req.a + req.b;
        rsp.ge  = 1'b0;
      end
      ALU_SUB: begin
        rsp.res = diff[ACC_W-1:0];
        rsp.ge  = ~diff[ACC_W];
      end
      default: begin
        rsp.res = '0;
        rsp.ge  = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/walus_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walus_cfg
// Alarm slot and snooze length registers with a slot read port.
// ----------------------------------------------------------------------------
module walus_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [walus_pkg::CFG_IDX_W-1:0]   wr_idx,
  input  logic [walus_pkg::SLOT_W-1:0]      wr_data,
  input  walus_pkg::slot_idx_t              rd_idx,
  output logic [walus_pkg::SLOT_W-1:0]      rd_slot,
  output logic [walus_pkg::SNOOZE_W-1:0]    snooze_min
);
  import walus_pkg::*;

  logic [SLOT_W-1:0]   slot_r   [SLOT_REGS];
  logic [SNOOZE_W-1:0] snooze_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_REGS; i++) slot_r[i] <= '0;
      snooze_r <= SNOOZE_W'(9);
    end else if (wr_en) begin
      if (wr_idx < CFG_IDX_W'(SLOT_REGS)) begin
        slot_r[wr_idx[1:0]] <= wr_data;
      end else if (wr_idx == REG_SNOOZE) begin
        snooze_r <= wr_data[SNOOZE_W-1:0];
      end
    end
  end

  assign rd_slot    = slot_r[rd_idx];
  assign snooze_min = snooze_r;

endmodule

`default_nettype wire

/* rtl/weekday_alarm_unit_with_snooze.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weekday_alarm_unit_with_snooze
// Weekly alarm unit with snooze, driven by date/time and button beats.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser kind, tdata date and time
//  out_    | out | out_tvalid/out_tready | tdata triggered, active flag/index
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  A beat runs these states when the result leaves at once: ST_CUR_HI and
//  ST_CUR_LO form the minute count in the shared adder, ST_DATE decodes the
//  kind and checks the date, then a time update scans one slot per cycle (up
//  to 4) or runs one snooze compare, and a snooze press on an active alarm
//  runs one add and two modulo passes; ST_DONE loads the output register and
//  ST_IDLE waits for the next accept. Dismiss, reserved kinds and a snooze
//  with no active alarm take the shortest path.
//  Reset is synchronous on rst_n. A new beat is taken while a result waits;
//  the sequencer holds in its last state until the output register is free.
// ----------------------------------------------------------------------------
module weekday_alarm_unit_with_snooze #(
  parameter int NUM_ALARMS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [39:0]                          in_tdata,  // year, month, day, weekday, hour, minute
  input  logic [1:0]                           in_tuser,  // kind
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata, // triggered, active_valid, active_index
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [walus_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [walus_pkg::SLOT_W-1:0]         cfg_data
);
  import walus_pkg::*;

  localparam int SCAN_SLOTS = (NUM_ALARMS < SLOT_REGS) ? NUM_ALARMS : SLOT_REGS;

  state_t state_r, state_nxt;

  // captured beat
  kind_t        kind_r;
  logic [11:0]  year_r;
  logic [3:0]   month_r;
  logic [4:0]   day_r;
  logic [2:0]   wday_r;
  logic [4:0]   hour_r;
  logic [5:0]   minute_r;

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                mod_pass_r, mod_pass_nxt;
  slot_idx_t           scan_idx_r, scan_idx_nxt;
  logic                fire_r, fire_nxt;

  logic [SLOT_REGS-1:0] fired_r, fired_nxt;
  logic                 active_r, active_nxt;
  slot_idx_t            active_slot_r, active_slot_nxt;
  logic [SNOOZE_W-1:0]  snz_end_r, snz_end_nxt;
  logic [11:0]          st_year_r, st_year_nxt;
  logic [3:0]           st_month_r, st_month_nxt;
  logic [4:0]           st_day_r, st_day_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_data_r, out_data_nxt;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;
  logic [SLOT_W-1:0]    rd_slot;
  logic [SNOOZE_W-1:0]  snooze_min;

  logic                 in_fire;
  logic [2:0]           wbit;
  logic [6:0]           wmask;
  logic                 slot_hit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  walus_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid & cfg_ready),
    .wr_idx     (cfg_index),
    .wr_data    (cfg_data),
    .rd_idx     (scan_idx_r),
    .rd_slot    (rd_slot),
    .snooze_min (snooze_min)
  );

  walus_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // weekday seven counts as Sunday
  assign wbit  = (wday_r < 3'(DAYS_PER_WEEK)) ? wday_r : 3'd0;
  assign wmask = rd_slot[SLOT_MASK_LSB +: 7];
  assign slot_hit = ~fired_r[scan_idx_r] & rd_slot[SLOT_EN_BIT] & wmask[wbit] &
                    (rd_slot[SLOT_HOUR_LSB +: 5] == hour_r) &
                    (rd_slot[5:0] == minute_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mod_pass_r    <= 1'b0;
      scan_idx_r    <= '0;
      fire_r        <= 1'b0;
      fired_r       <= '0;
      active_r      <= 1'b0;
      active_slot_r <= '0;
      snz_end_r     <= '0;
      st_year_r     <= '0;
      st_month_r    <= '0;
      st_day_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mod_pass_r    <= mod_pass_nxt;
      scan_idx_r    <= scan_idx_nxt;
      fire_r        <= fire_nxt;
      fired_r       <= fired_nxt;
      active_r      <= active_nxt;
      active_slot_r <= active_slot_nxt;
      snz_end_r     <= snz_end_nxt;
      st_year_r     <= st_year_nxt;
      st_month_r    <= st_month_nxt;
      st_day_r      <= st_day_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      kind_r   <= kind_t'(in_tuser);
      year_r   <= in_tdata[11:0];
      month_r  <= in_tdata[15:12];
      day_r    <= in_tdata[20:16];
      wday_r   <= in_tdata[23:21];
      hour_r   <= in_tdata[28:24];
      minute_r <= in_tdata[34:29];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    acc_nxt         = acc_r;
    mod_pass_nxt    = mod_pass_r;
    scan_idx_nxt    = scan_idx_r;
    fire_nxt        = fire_r;
    fired_nxt       = fired_r;
    active_nxt      = active_r;
    active_slot_nxt = active_slot_r;
    snz_end_nxt     = snz_end_r;
    st_year_nxt     = st_year_r;
    st_month_nxt    = st_month_r;
    st_day_nxt      = st_day_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    out_data_nxt    = out_data_r;
    alu_req.op      = ALU_ADD;
    alu_req.a       = acc_r;
    alu_req.b       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          fire_nxt  = 1'b0;
          state_nxt = ST_CUR_HI;
        end
      end
      ST_CUR_HI: begin
        // hour * 60 = hour * 64 - hour * 4
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, hour_r, 6'b0};
        alu_req.b  = {5'b0, hour_r, 2'b0};
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_CUR_LO;
      end
      ST_CUR_LO: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = {6'b0, minute_r};
        acc_nxt    = alu_rsp.res;
        state_nxt  = ST_DATE;
      end
      ST_DATE: begin
        unique case (kind_r)
          KIND_TIME: begin
            if (year_r != st_year_r || month_r != st_month_r || day_r != st_day_r) begin
              fired_nxt    = '0;
              st_year_nxt  = year_r;
              st_month_nxt = month_r;
              st_day_nxt   = day_r;
            end
            scan_idx_nxt = '0;
            state_nxt    = (snz_end_r != '0) ? ST_SNZ_CMP : ST_SCAN;
          end
          KIND_SNOOZE: begin
            state_nxt = active_r ? ST_SNZ_ADD : ST_DONE;
          end
          KIND_DISMISS: begin
            active_nxt      = 1'b0;
            active_slot_nxt = '0;
            snz_end_nxt     = '0;
            state_nxt       = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SNZ_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = {1'b0, snz_end_r};
        if (alu_rsp.ge) begin
          snz_end_nxt = '0;
          fire_nxt    = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        // fired flags of this beat see the date clear from ST_DATE
        if (slot_hit) begin
          fired_nxt[scan_idx_r] = 1'b1;
          active_nxt            = 1'b1;
          active_slot_nxt       = scan_idx_r;
          fire_nxt              = 1'b1;
          state_nxt             = ST_DONE;
        end else if (scan_idx_r == 2'(SCAN_SLOTS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 2'd1;
        end
      end
      ST_SNZ_ADD: begin
        alu_req.op   = ALU_ADD;
        alu_req.b    = {1'b0, snooze_min};
        acc_nxt      = alu_rsp.res;
        mod_pass_nxt = 1'b0;
        state_nxt    = ST_SNZ_MOD;
      end
      ST_SNZ_MOD: begin
        // sum stays below 3 * 1440, so two conditional subtracts suffice
        alu_req.op = ALU_SUB;
        alu_req.b  = ACC_W'(MINUTES_PER_DAY);
        if (alu_rsp.ge) acc_nxt = alu_rsp.res;
        if (mod_pass_r) begin
          snz_end_nxt     = alu_rsp.ge ? alu_rsp.res[SNOOZE_W-1:0] : acc_r[SNOOZE_W-1:0];
          active_nxt      = 1'b0;
          active_slot_nxt = '0;
          state_nxt       = ST_DONE;
        end
        mod_pass_nxt = 1'b1;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'b0, active_r ? active_slot_r : 2'd0, active_r, fire_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/walus_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walus_chk
// Port-level checks of the alarm unit, bound to the top level.
// ----------------------------------------------------------------------------
module walus_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [7:0]                       out_tdata
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one beat at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while sequencer busy");

  // no active alarm means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[3:2] == 2'd0)
    else $error("active index set with no active alarm");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:4] == 4'd0)
    else $error("result padding not zero");

endmodule

bind weekday_alarm_unit_with_snooze walus_chk u_walus_chk (.*);

`default_nettype wire
